// ===== rtl/polynomial_lens_distortion_map_core_assert.svh =====
// assertion macros of the lens distortion map rtl, included by plm_seq
`ifndef POLYNOMIAL_LENS_DISTORTION_MAP_CORE_ASSERT_SVH
`define POLYNOMIAL_LENS_DISTORTION_MAP_CORE_ASSERT_SVH

// property checked on every clock edge outside reset
`define PLM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("plm assertion failed");

// property checked on every clock edge, reset included
`define PLM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("plm assertion failed");

`endif

// ===== rtl/plm_pkg.sv =====
// types, constants and helpers of the lens distortion map
package plm_pkg;

  localparam int MAX_ITERATIONS  = 50;
  localparam int COORD_FRAC_BITS = 24;
  localparam int COEF_FRAC_BITS  = 46;
  localparam int COEF_SPLIT      = 23;
  localparam int COORD_W         = 32;
  localparam int COEF_W          = 48;
  localparam int TOL_W           = 16;
  localparam int IDX_W           = 2;
  localparam int ACC_W           = 36;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd17;

  typedef enum logic [IDX_W-1:0] {
    REG_COEF_RADIAL,
    REG_COEF_TILT_Y,
    REG_COEF_TILT_X,
    REG_TOLERANCE
  } reg_index_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] e2;
    logic signed [COEF_W-1:0] e5;
    logic signed [COEF_W-1:0] e6;
    logic [TOL_W-1:0]         tol;
  } cfg_t;

  typedef struct packed {
    logic                      start;
    logic                      is_coef;
    logic signed [COORD_W-1:0] a;
    logic signed [COEF_W-1:0]  b;
  } mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [COORD_W-1:0] result;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LO,
    PH_HI,
    PH_SUM,
    PH_ROUND
  } mul_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_CHECK,
    ST_DONE
  } seq_state_t;

  // closed-form steps first, then the steps of one iteration
  typedef enum logic [4:0] {
    STEP_D_XX,
    STEP_D_YY,
    STEP_D_A,
    STEP_D_B,
    STEP_D_C,
    STEP_D_XO,
    STEP_D_YO,
    STEP_I_XX,
    STEP_I_YY,
    STEP_I_XY,
    STEP_I_P,
    STEP_I_Q,
    STEP_I_XD1,
    STEP_I_XD2,
    STEP_I_XD3,
    STEP_I_YD1,
    STEP_I_YD2,
    STEP_I_YD3
  } step_t;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 36'sh07FFFFFFF;
  localparam logic signed [ACC_W-1:0] SAT_MIN = 36'shF80000000;

  // clamp a wide sum to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/polynomial_lens_distortion_map_core.sv =====
// lens distortion map top level: config, shared multiplier, sequencer
// direction 0 does 4 coordinate and 3 coefficient multiplies
// direction 1 runs up to MAX_ITERATIONS iterations of 5 coordinate and 6 coefficient multiplies
// a coordinate multiply passes phases LO and ROUND, a coefficient multiply LO, HI, SUM and ROUND, on the one multiplier
// one item at a time; input ready again once the result register takes the result
// rst synchronous: coefficients 0, tolerance 17, no result pending
module polynomial_lens_distortion_map_core #(
  parameter int MAX_ITERATIONS  = plm_pkg::MAX_ITERATIONS,
  parameter int COORD_FRAC_BITS = plm_pkg::COORD_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [63:0]                s_tdata,   // x_in, y_in
  input  logic                       s_tuser,   // direction
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [63:0]                m_tdata,   // x_out, y_out
  output logic                       m_tuser,   // converged
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [plm_pkg::IDX_W-1:0]  cfg_index,
  input  logic [plm_pkg::COEF_W-1:0] cfg_data
);

  plm_pkg::cfg_t     cfg;
  plm_pkg::mul_req_t mul_req;
  plm_pkg::mul_rsp_t mul_rsp;

  plm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  plm_mul #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  plm_seq #(
    .MAX_ITERATIONS  (MAX_ITERATIONS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg      (cfg),
    .mul_req  (mul_req),
    .mul_rsp  (mul_rsp)
  );

endmodule

// ===== rtl/plm_cfg.sv =====
// configuration registers of the lens distortion map
module plm_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [plm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [plm_pkg::COEF_W-1:0]   cfg_data,
  output plm_pkg::cfg_t                cfg
);

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.e2  <= '0;
      cfg.e5  <= '0;
      cfg.e6  <= '0;
      cfg.tol <= plm_pkg::TOL_RESET;
    end else if (cfg_valid) begin
      case (plm_pkg::reg_index_t'(cfg_index))
        plm_pkg::REG_COEF_RADIAL: cfg.e2  <= cfg_data;
        plm_pkg::REG_COEF_TILT_Y: cfg.e5  <= cfg_data;
        plm_pkg::REG_COEF_TILT_X: cfg.e6  <= cfg_data;
        plm_pkg::REG_TOLERANCE:   cfg.tol <= cfg_data[plm_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/plm_mul.sv =====
// shared multi-cycle rounding and saturating multiplier
module plm_mul #(
  parameter int COORD_FRAC_BITS = plm_pkg::COORD_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  plm_pkg::mul_req_t req,
  output plm_pkg::mul_rsp_t rsp
);

  localparam int SPLIT = plm_pkg::COEF_SPLIT;
  localparam int COEF_SHIFT = plm_pkg::COEF_FRAC_BITS - SPLIT;
  localparam logic [63:0] RND_CC = 64'd1 << (COORD_FRAC_BITS - 1);
  localparam logic [63:0] RND_COEF = 64'd1 << (plm_pkg::COEF_FRAC_BITS - 24);

  plm_pkg::mul_phase_t phase, phase_next;
  logic [31:0] ma;
  logic [47:0] mb;
  logic        neg;
  logic        is_coef;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] mag_r;

  // one 32 by 32 multiplier, b side picks a slice of the magnitude
  always_comb begin
    if (phase == plm_pkg::PH_HI) begin
      mul_b = {7'd0, mb[47:SPLIT]};
    end else if (is_coef) begin
      mul_b = {9'd0, mb[SPLIT-1:0]};
    end else begin
      mul_b = mb[31:0];
    end
  end
  assign mul_p = ma * mul_b;

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      plm_pkg::PH_IDLE:  if (req.start) phase_next = plm_pkg::PH_LO;
      plm_pkg::PH_LO:    phase_next = is_coef ? plm_pkg::PH_HI : plm_pkg::PH_ROUND;
      plm_pkg::PH_HI:    phase_next = plm_pkg::PH_SUM;
      plm_pkg::PH_SUM:   phase_next = plm_pkg::PH_ROUND;
      plm_pkg::PH_ROUND: phase_next = plm_pkg::PH_IDLE;
      default:           phase_next = plm_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= plm_pkg::PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // operand capture and partial products
  always_ff @(posedge clk) begin
    case (phase)
      plm_pkg::PH_IDLE: begin
        if (req.start) begin
          ma      <= req.a[31] ? 32'(-req.a) : 32'(req.a);
          mb      <= req.b[47] ? 48'(-req.b) : 48'(req.b);
          neg     <= req.a[31] ^ req.b[47];
          is_coef <= req.is_coef;
        end
      end
      plm_pkg::PH_LO:  acc  <= mul_p;
      plm_pkg::PH_HI:  prod <= mul_p;
      plm_pkg::PH_SUM: acc  <= prod + (acc >> SPLIT);
      default: ;
    endcase
  end

  // rounding and saturation of the magnitude
  always_comb begin
    if (is_coef) begin
      mag_r = (acc + RND_COEF) >> COEF_SHIFT;
    end else begin
      mag_r = (acc + RND_CC) >> COORD_FRAC_BITS;
    end
  end

  // outputs
  always_comb begin
    rsp.done = (phase == plm_pkg::PH_ROUND);
    if (neg) begin
      rsp.result = (mag_r >= 64'h80000000) ? 32'sh80000000 : -$signed(mag_r[31:0]);
    end else begin
      rsp.result = (mag_r > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(mag_r[31:0]);
    end
  end

endmodule

// ===== rtl/plm_seq.sv =====
// step sequencer, working registers and result register
module plm_seq #(
  parameter int MAX_ITERATIONS  = plm_pkg::MAX_ITERATIONS,
  parameter int COORD_FRAC_BITS = plm_pkg::COORD_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,
  output logic              m_tuser,
  input  plm_pkg::cfg_t     cfg,
  output plm_pkg::mul_req_t mul_req,
  input  plm_pkg::mul_rsp_t mul_rsp
);

  localparam int IW = $clog2(MAX_ITERATIONS + 1);
  localparam int AW = plm_pkg::ACC_W;
  localparam logic signed [AW-1:0] ONE = 36'sd1 <<< COORD_FRAC_BITS;

  plm_pkg::seq_state_t state, state_next;
  plm_pkg::step_t      step;
  logic [IW-1:0]       iter;
  logic                dir;
  logic                have_prev;
  logic                conv;
  logic signed [31:0]  x, y, xt, yt, xp, yp, xx, yy, xy, rr, p, q;
  logic signed [AW-1:0] acc;
  logic signed [31:0]  r;
  logic signed [32:0]  dx, dy;
  logic [32:0]         adx, ady;
  logic                check_ok;
  logic                last_iter;
  logic                out_free;
  logic                accept;
  logic                step_last;
  logic signed [31:0]  opa, opb;
  logic                op_coef;
  logic signed [47:0]  opc;

  assign r        = mul_rsp.result;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // convergence test against the previous iterate
  assign dx        = 33'(xt) - 33'(xp);
  assign dy        = 33'(yt) - 33'(yp);
  assign adx       = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady       = dy[32] ? 33'(-dy) : 33'(dy);
  assign check_ok  = have_prev && (adx <= 33'(cfg.tol)) && (ady <= 33'(cfg.tol));
  assign last_iter = (iter == IW'(MAX_ITERATIONS - 1));
  assign step_last = (step == plm_pkg::STEP_D_YO) || (step == plm_pkg::STEP_I_YD3);

  // operand selection for the current step
  always_comb begin
    opa = x; opb = x; opc = cfg.e2; op_coef = 1'b0;
    case (step)
      plm_pkg::STEP_D_XX:  begin opa = x;  opb = x; end
      plm_pkg::STEP_D_YY:  begin opa = y;  opb = y; end
      plm_pkg::STEP_D_A:   begin opa = rr; opc = cfg.e2; op_coef = 1'b1; end
      plm_pkg::STEP_D_B:   begin opa = y;  opc = cfg.e5; op_coef = 1'b1; end
      plm_pkg::STEP_D_C:   begin opa = x;  opc = cfg.e6; op_coef = 1'b1; end
      plm_pkg::STEP_D_XO:  begin opa = x;  opb = p; end
      plm_pkg::STEP_D_YO:  begin opa = y;  opb = p; end
      plm_pkg::STEP_I_XX:  begin opa = xt; opb = xt; end
      plm_pkg::STEP_I_YY:  begin opa = yt; opb = yt; end
      plm_pkg::STEP_I_XY:  begin opa = xt; opb = yt; end
      plm_pkg::STEP_I_P:   begin opa = xt; opb = rr; end
      plm_pkg::STEP_I_Q:   begin opa = yt; opb = rr; end
      plm_pkg::STEP_I_XD1: begin opa = p;  opc = cfg.e2; op_coef = 1'b1; end
      plm_pkg::STEP_I_XD2: begin opa = xy; opc = cfg.e5; op_coef = 1'b1; end
      plm_pkg::STEP_I_XD3: begin opa = xx; opc = cfg.e6; op_coef = 1'b1; end
      plm_pkg::STEP_I_YD1: begin opa = q;  opc = cfg.e2; op_coef = 1'b1; end
      plm_pkg::STEP_I_YD2: begin opa = yy; opc = cfg.e5; op_coef = 1'b1; end
      plm_pkg::STEP_I_YD3: begin opa = xy; opc = cfg.e6; op_coef = 1'b1; end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      plm_pkg::ST_IDLE:  if (accept) state_next = plm_pkg::ST_ISSUE;
      plm_pkg::ST_ISSUE: state_next = plm_pkg::ST_WAIT;
      plm_pkg::ST_WAIT: begin
        if (mul_rsp.done) begin
          if (step == plm_pkg::STEP_D_YO) begin
            state_next = plm_pkg::ST_DONE;
          end else if (step == plm_pkg::STEP_I_YD3) begin
            state_next = plm_pkg::ST_CHECK;
          end else begin
            state_next = plm_pkg::ST_ISSUE;
          end
        end
      end
      plm_pkg::ST_CHECK: begin
        state_next = (check_ok || last_iter) ? plm_pkg::ST_DONE : plm_pkg::ST_ISSUE;
      end
      plm_pkg::ST_DONE:  if (out_free) state_next = plm_pkg::ST_IDLE;
      default:           state_next = plm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready        = (state == plm_pkg::ST_IDLE);
    mul_req.start   = (state == plm_pkg::ST_ISSUE);
    mul_req.is_coef = op_coef;
    mul_req.a       = opa;
    mul_req.b       = op_coef ? opc : {{16{opb[31]}}, opb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      plm_pkg::ST_IDLE: begin
        if (accept) begin
          x         <= s_tdata[31:0];
          y         <= s_tdata[63:32];
          xt        <= s_tdata[31:0];
          yt        <= s_tdata[63:32];
          dir       <= s_tuser;
          step      <= s_tuser ? plm_pkg::STEP_I_XX : plm_pkg::STEP_D_XX;
          iter      <= '0;
          have_prev <= 1'b0;
          conv      <= 1'b0;
        end
      end
      plm_pkg::ST_WAIT: begin
        if (mul_rsp.done) begin
          if (!step_last) step <= plm_pkg::step_t'(step + 5'd1);
          case (step)
            plm_pkg::STEP_D_XX:  xx  <= r;
            plm_pkg::STEP_D_YY:  begin yy <= r; rr <= plm_pkg::sat32(AW'(xx) + AW'(r)); end
            plm_pkg::STEP_D_A:   acc <= ONE - AW'(r);
            plm_pkg::STEP_D_B:   acc <= acc - AW'(r);
            plm_pkg::STEP_D_C:   p   <= plm_pkg::sat32(acc - AW'(r));
            plm_pkg::STEP_D_XO:  xt  <= r;
            plm_pkg::STEP_D_YO:  begin yt <= r; conv <= 1'b1; end
            plm_pkg::STEP_I_XX:  xx  <= r;
            plm_pkg::STEP_I_YY:  begin yy <= r; rr <= plm_pkg::sat32(AW'(xx) + AW'(r)); end
            plm_pkg::STEP_I_XY:  xy  <= r;
            plm_pkg::STEP_I_P:   p   <= r;
            plm_pkg::STEP_I_Q:   q   <= r;
            plm_pkg::STEP_I_XD1: acc <= AW'(r);
            plm_pkg::STEP_I_XD2: acc <= acc + AW'(r);
            plm_pkg::STEP_I_XD3: xt  <= plm_pkg::sat32(AW'(x) + AW'(plm_pkg::sat32(acc + AW'(r))));
            plm_pkg::STEP_I_YD1: acc <= AW'(r);
            plm_pkg::STEP_I_YD2: acc <= acc + AW'(r);
            plm_pkg::STEP_I_YD3: yt  <= plm_pkg::sat32(AW'(y) + AW'(plm_pkg::sat32(acc + AW'(r))));
            default: ;
          endcase
        end
      end
      plm_pkg::ST_CHECK: begin
        if (check_ok) begin
          conv <= 1'b1;
        end else if (!last_iter) begin
          xp        <= xt;
          yp        <= yt;
          have_prev <= 1'b1;
          iter      <= iter + IW'(1);
          step      <= plm_pkg::STEP_I_XX;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == plm_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == plm_pkg::ST_DONE && out_free) begin
      m_tdata <= {yt, xt};
      m_tuser <= conv;
    end
  end

`include "polynomial_lens_distortion_map_core_assert.svh"

  `PLM_ASSERT(a_ready_only_idle, s_tready |-> state == plm_pkg::ST_IDLE)
  `PLM_ASSERT(a_done_in_wait, mul_rsp.done |-> state == plm_pkg::ST_WAIT)
  `PLM_ASSERT(a_iter_range, (state != plm_pkg::ST_IDLE) |-> iter < IW'(MAX_ITERATIONS))
  `PLM_ASSERT(a_closed_form_conv, (state == plm_pkg::ST_DONE && !dir) |-> conv)
  `PLM_ASSERT_ALWAYS(a_no_start_in_reset, rst |=> !mul_req.start)

endmodule

// ===== sim/polynomial_lens_distortion_map_core_test.sv =====
// self-checking testbench of the lens distortion map: stream stimulus, fixed-point predictor
`timescale 1ns / 100ps

module polynomial_lens_distortion_map_core_test;

  localparam int  IDLE_LIMIT = 20000;
  localparam int  HOLD_CYCLES = 3000;
  localparam int  F = plm_pkg::COORD_FRAC_BITS;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  typedef struct {
    logic        dir;
    logic [31:0] x;
    logic [31:0] y;
  } point_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        conv;
  } mapped_t;

  typedef struct {
    plm_pkg::reg_index_t idx;
    logic [47:0]         data;
  } reg_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [plm_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [plm_pkg::COEF_W-1:0] cfg_data = '0;

  // model copy of the registers
  logic [47:0] m_e2 = '0, m_e5 = '0, m_e6 = '0;
  logic [15:0] m_tol = plm_pkg::TOL_RESET;

  point_t     points_pending[$];
  mapped_t    mapped_expected[$];
  reg_write_t writes_pending[$];
  point_t     cur_point;
  int         errors = 0;
  int         points_taken = 0;
  int         results_seen = 0;
  int         idle_cycles = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  polynomial_lens_distortion_map_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // fixed-point helpers
  function automatic longint clamp32(longint v);
    if (v > I32_MAX) return I32_MAX;
    if (v < I32_MIN) return I32_MIN;
    return v;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic longint signed_clamp(bit neg, longint unsigned m);
    if (neg) return (m >= 64'd2147483648) ? I32_MIN : -longint'(m);
    return (m > 64'd2147483647) ? I32_MAX : longint'(m);
  endfunction

  // coordinate times coordinate, round half away, saturate
  function automatic longint coord_mul(longint a, longint b);
    longint unsigned p;
    p = abs64(a) * abs64(b);
    p = (p + (64'd1 << (F - 1))) >> F;
    return signed_clamp((a < 0) != (b < 0), p);
  endfunction

  // coordinate times Q2.46 coefficient, split to keep 64 bits
  function automatic longint coef_mul(longint a, longint e);
    longint unsigned ma, me, hi, lo, q;
    ma = abs64(a);
    me = abs64(e);
    hi = ma * (me >> 23);
    lo = ma * (me & ((64'd1 << 23) - 1));
    q = hi + (lo >> 23);
    q = (q + (64'd1 << (plm_pkg::COEF_FRAC_BITS - 24))) >> (plm_pkg::COEF_FRAC_BITS - 23);
    return signed_clamp((a < 0) != (e < 0), q);
  endfunction

  function automatic mapped_t map_point(point_t p);
    longint e2, e5, e6, tol, x, y, rr, t, xt, yt, xp, yp, xx, yy, xy, xd, yd, dx, dy;
    bit have_prev;
    mapped_t r;
    e2 = longint'($signed(m_e2));
    e5 = longint'($signed(m_e5));
    e6 = longint'($signed(m_e6));
    tol = longint'(m_tol);
    x = longint'($signed(p.x));
    y = longint'($signed(p.y));
    r.conv = 1'b0;
    if (!p.dir) begin
      rr = clamp32(coord_mul(x, x) + coord_mul(y, y));
      t = clamp32((longint'(1) << F) - coef_mul(rr, e2) - coef_mul(y, e5) - coef_mul(x, e6));
      r.x = 32'(coord_mul(x, t));
      r.y = 32'(coord_mul(y, t));
      r.conv = 1'b1;
    end else begin
      xt = x; yt = y; xp = 0; yp = 0;
      have_prev = 1'b0;
      for (int i = 0; i < plm_pkg::MAX_ITERATIONS; i++) begin
        xx = coord_mul(xt, xt);
        yy = coord_mul(yt, yt);
        xy = coord_mul(xt, yt);
        rr = clamp32(xx + yy);
        xd = clamp32(coef_mul(coord_mul(xt, rr), e2) + coef_mul(xy, e5) + coef_mul(xx, e6));
        yd = clamp32(coef_mul(coord_mul(yt, rr), e2) + coef_mul(yy, e5) + coef_mul(xy, e6));
        xt = clamp32(x + xd);
        yt = clamp32(y + yd);
        dx = xt - xp;
        dy = yt - yp;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (have_prev && dx <= tol && dy <= tol) begin
          r.conv = 1'b1;
          break;
        end
        xp = xt;
        yp = yt;
        have_prev = 1'b1;
      end
      r.x = 32'(xt);
      r.y = 32'(yt);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s at result %0d: got %h expected %h", what, results_seen, got, want);
    errors++;
  endtask

  // random idling on both sides, none while points 500 to 699 are taken
  function automatic bit idle_now();
    if (points_taken >= 500 && points_taken < 700) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  // register write channel
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (plm_pkg::reg_index_t'(cfg_index))
          plm_pkg::REG_COEF_RADIAL: m_e2 = cfg_data;
          plm_pkg::REG_COEF_TILT_Y: m_e5 = cfg_data;
          plm_pkg::REG_COEF_TILT_X: m_e6 = cfg_data;
          plm_pkg::REG_TOLERANCE:   m_tol = cfg_data[15:0];
          default: ;
        endcase
        void'(writes_pending.pop_front());
      end
      if (writes_pending.size() > 0) begin
        cfg_valid <= 1'b1;
        cfg_index <= writes_pending[0].idx;
        cfg_data  <= writes_pending[0].data;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  // input driver: predict on each transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        mapped_expected.push_back(map_point(cur_point));
        points_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (points_pending.size() > 0 && !idle_now()) begin
          cur_point = points_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= cur_point.dir;
          s_tdata  <= {cur_point.y, cur_point.x};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor with receiver hold-off
  always @(posedge clk) begin
    mapped_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (mapped_expected.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
        end else begin
          want = mapped_expected.pop_front();
          if (m_tdata[31:0] !== want.x) report_mismatch("x_out", m_tdata[31:0], want.x);
          if (m_tdata[63:32] !== want.y) report_mismatch("y_out", m_tdata[63:32], want.y);
          if (m_tuser !== want.conv) begin
            report_mismatch("converged", 32'(m_tuser), 32'(want.conv));
          end
        end
        results_seen++;
      end
      if (!hold_done && results_seen == 100) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left--;
      m_tready <= (hold_left == 0) && !idle_now();
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_coord();
    logic [31:0] v;
    case ($urandom_range(4))
      0: v = $urandom;
      1: v = $signed($urandom) >>> $urandom_range(31);
      2: begin
        case ($urandom_range(3))
          0: v = 32'h7FFFFFFF;
          1: v = 32'h80000000;
          2: v = 32'h00000000;
          default: v = 32'hFFFFFFFF;
        endcase
      end
      default: v = $signed($urandom) >>> (4 + $urandom_range(8)); // within a few mm
    endcase
    return v;
  endfunction

  function automatic logic [47:0] pick_coef();
    logic signed [47:0] v;
    v = 48'({$urandom, $urandom});
    case ($urandom_range(3))
      0: v = '0;
      1: ;
      default: v = v >>> (14 + $urandom_range(26)); // physically plausible sizes
    endcase
    return v;
  endfunction

  task automatic add_point(logic dir, logic [31:0] x, logic [31:0] y);
    point_t p;
    p.dir = dir;
    p.x = x;
    p.y = y;
    points_pending.push_back(p);
  endtask

  task automatic drain();
    while (points_pending.size() > 0 || mapped_expected.size() > 0 || s_tvalid)
      @(posedge clk);
  endtask

  task automatic set_regs(logic [47:0] e2, logic [47:0] e5, logic [47:0] e6, logic [15:0] tol);
    reg_write_t w;
    w.idx = plm_pkg::REG_COEF_RADIAL; w.data = e2;       writes_pending.push_back(w);
    w.idx = plm_pkg::REG_COEF_TILT_Y; w.data = e5;       writes_pending.push_back(w);
    w.idx = plm_pkg::REG_COEF_TILT_X; w.data = e6;       writes_pending.push_back(w);
    w.idx = plm_pkg::REG_TOLERANCE;   w.data = 48'(tol); writes_pending.push_back(w);
    while (writes_pending.size() > 0 || cfg_valid) @(posedge clk);
  endtask

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) add_point(1'($urandom_range(1)), pick_coord(), pick_coord());
  endtask

  task automatic directed_points();
    logic [31:0] corners[5];
    corners = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h01000000, 32'hFF000000};
    for (int d = 0; d < 2; d++)
      for (int k = 0; k < 5; k++) add_point(1'(d), corners[k], corners[(k + 2) % 5]);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: identity map, iteration converges on its second pass
    directed_points();
    drain();

    // plausible camera coefficients, default tolerance
    set_regs(48'sd700000000, -48'sd30000000, 48'sd20000000, 16'd17);
    directed_points();
    random_points(150);
    drain();

    // extreme coefficients with zero tolerance: saturation and no convergence
    set_regs(48'h7FFFFFFFFFFF, 48'h800000000000, 48'h7FFFFFFFFFFF, 16'd0);
    directed_points();
    random_points(60);
    drain();

    // opposite extremes, widest tolerance
    set_regs(48'h800000000000, 48'h7FFFFFFFFFFF, 48'h800000000000, 16'hFFFF);
    random_points(60);
    drain();

    // random settings
    for (int ph = 0; ph < 7; ph++) begin
      set_regs(pick_coef(), pick_coef(), pick_coef(),
               ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(64)));
      random_points(130);
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && mapped_expected.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
